@@ rtl/ext2il_pkg.sv @@
// shared types and constants for the ext2 inode locator
// no dependencies
package ext2il_pkg;

    localparam int MAX_GROUPS   = 1024;
    localparam int GRP_AW       = $clog2(MAX_GROUPS);
    localparam int DIV_W        = 32;
    localparam int GCNT_W       = GRP_AW + 1;

    // configuration register indexes
    localparam logic [2:0] CFG_INODE_COUNT = 3'd0;
    localparam logic [2:0] CFG_IPG         = 3'd1;
    localparam logic [2:0] CFG_REVISION    = 3'd2;
    localparam logic [2:0] CFG_RAW_SIZE    = 3'd3;
    localparam logic [2:0] CFG_BSIZE_LOG   = 3'd4;
    localparam logic [2:0] CFG_GROUP_COUNT = 3'd5;

    // item kinds and result codes
    localparam logic       FUNC_LOAD   = 1'b0;
    localparam logic       FUNC_LOCATE = 1'b1;
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_INO  = 2'd1;
    localparam logic [1:0] ST_BAD_GRP  = 2'd2;

    localparam logic [12:0] DEF_INODE_SIZE = 13'd128;

    // fields that ride along with an item through the divider
    typedef struct packed {
        logic              func;
        logic [GRP_AW-1:0] slot;
        logic [31:0]       start;
        logic              bad_ino;
    } side_t;

endpackage

@@ rtl/ext2il_div.sv @@
// pipelined restoring divider, one quotient bit per stage
// depends on ext2il_pkg
module ext2il_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [31:0]               in_num,
    input  logic [32:0]               in_den,
    input  ext2il_pkg::side_t         in_side,
    output logic                      out_valid,
    output logic [31:0]               out_quot,
    output logic [31:0]               out_rem,
    output ext2il_pkg::side_t         out_side
);
    import ext2il_pkg::*;

    logic [DIV_W-1:0] vld_reg;
    logic [31:0]      num_reg [DIV_W];
    logic [31:0]      rem_reg [DIV_W];
    logic [31:0]      quo_reg [DIV_W];
    side_t            side_reg [DIV_W];

    logic [31:0]      num_next [DIV_W];
    logic [31:0]      rem_next [DIV_W];
    logic [31:0]      quo_next [DIV_W];

    // one shift and trial subtract per stage
    always_comb begin
        logic [31:0] n_prev;
        logic [31:0] r_prev;
        logic [31:0] q_prev;
        logic [32:0] trial;
        for (int k = 0; k < DIV_W; k++) begin
            n_prev = (k == 0) ? in_num : num_reg[(k == 0) ? 0 : k - 1];
            r_prev = (k == 0) ? 32'd0  : rem_reg[(k == 0) ? 0 : k - 1];
            q_prev = (k == 0) ? 32'd0  : quo_reg[(k == 0) ? 0 : k - 1];
            trial  = {r_prev, n_prev[31]};
            num_next[k] = {n_prev[30:0], 1'b0};
            if (trial >= in_den) begin
                rem_next[k] = 32'(trial - in_den);
                quo_next[k] = {q_prev[30:0], 1'b1};
            end else begin
                rem_next[k] = trial[31:0];
                quo_next[k] = {q_prev[30:0], 1'b0};
            end
        end
    end

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_W-2:0], in_valid};
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < DIV_W; k++) begin
                num_reg[k]  <= num_next[k];
                rem_reg[k]  <= rem_next[k];
                quo_reg[k]  <= quo_next[k];
                side_reg[k] <= (k == 0) ? in_side : side_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign out_valid = vld_reg[DIV_W-1];
    assign out_quot  = quo_reg[DIV_W-1];
    assign out_rem   = rem_reg[DIV_W-1];
    assign out_side  = side_reg[DIV_W-1];

endmodule

@@ rtl/ext2_inode_locator_core.sv @@
// ext2 inode locator top level: config registers, group table, pipeline
// depends on ext2il_pkg and ext2il_div
//
// Loads write the group table and locates turn an inode number into a
// filesystem block and byte offset. One item is taken per cycle while the
// result side is not stalled. Each item passes 35 register stages: the input
// register, 32 divider stages of one quotient bit each, the table read and
// multiply, then the add and output register. A stall on the result side holds
// the whole pipeline. Table entries read before being loaded return undefined
// addresses. Write configuration only while no items are in flight.
module ext2_inode_locator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // group_slot, table_start_block, inode_number
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // status, block_number, byte_offset
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import ext2il_pkg::*;

    logic              adv;
    logic [31:0]       ino_cnt_reg;
    logic [31:0]       ipg_reg;
    logic              rev_reg;
    logic [12:0]       raw_size_reg;
    logic [1:0]        bsl_reg;
    logic [GCNT_W-1:0] gcnt_reg;

    // configuration writes
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ino_cnt_reg  <= 32'd0;
            ipg_reg      <= 32'd2048;
            rev_reg      <= 1'b0;
            raw_size_reg <= 13'd128;
            bsl_reg      <= 2'd0;
            gcnt_reg     <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_INODE_COUNT: ino_cnt_reg  <= cfg_data;
                CFG_IPG:         ipg_reg      <= cfg_data;
                CFG_REVISION:    rev_reg      <= cfg_data[0];
                CFG_RAW_SIZE:    raw_size_reg <= cfg_data[12:0];
                CFG_BSIZE_LOG:   bsl_reg      <= cfg_data[1:0];
                CFG_GROUP_COUNT: gcnt_reg     <= cfg_data[GCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline moves when the output slot is free or being taken
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // input stage: range check and index
    logic        in_vld_reg;
    logic [31:0] idx_reg;
    side_t       in_side_reg;
    logic [31:0] ino;

    assign ino = s_tdata[73:42];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (adv) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            idx_reg             <= ino - 32'd1;
            in_side_reg.func    <= s_tuser;
            in_side_reg.slot    <= s_tdata[GRP_AW-1:0];
            in_side_reg.start   <= s_tdata[41:10];
            in_side_reg.bad_ino <= (ino == 32'd0) || (ino > ino_cnt_reg);
        end
    end

    // group and slot within group
    logic        dv_vld;
    logic [31:0] dv_quot;
    logic [31:0] dv_rem;
    side_t       dv_side;

    ext2il_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (in_vld_reg),
        .in_num    (idx_reg),
        .in_den    ({ipg_reg == 32'd0, ipg_reg}),
        .in_side   (in_side_reg),
        .out_valid (dv_vld),
        .out_quot  (dv_quot),
        .out_rem   (dv_rem),
        .out_side  (dv_side)
    );

    // table stage: load write, locate read, slot times inode size
    logic [31:0]       tbl_mem [MAX_GROUPS];
    logic              tb_vld_reg;
    side_t             tb_side_reg;
    logic              tb_bad_grp_reg;
    logic [44:0]       tb_bytes_reg;
    logic [31:0]       tb_start_reg;
    logic [GCNT_W-1:0] groups;
    logic [12:0]       isize;

    assign groups = (gcnt_reg > GCNT_W'(MAX_GROUPS)) ? GCNT_W'(MAX_GROUPS) : gcnt_reg;
    assign isize  = (!rev_reg || raw_size_reg == 13'd0) ? DEF_INODE_SIZE : raw_size_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (dv_vld && dv_side.func == FUNC_LOAD) begin
                tbl_mem[dv_side.slot] <= dv_side.start;
            end
            tb_start_reg <= tbl_mem[dv_quot[GRP_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tb_vld_reg <= 1'b0;
        end else if (adv) begin
            tb_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tb_side_reg    <= dv_side;
            tb_bad_grp_reg <= dv_quot >= {{(32-GCNT_W){1'b0}}, groups};
            tb_bytes_reg   <= {13'd0, dv_rem} * {32'd0, isize};
        end
    end

    // output stage: block add, offset mask, status
    logic        out_vld_reg;
    logic [63:0] out_data_reg;
    logic [1:0]  lg;
    logic [3:0]  shamt;
    logic [1:0]  status;
    logic [44:0] blk;
    logic [11:0] off;

    assign lg    = (bsl_reg == 2'd3) ? 2'd2 : bsl_reg;
    assign shamt = 4'd10 + {2'd0, lg};

    always_comb begin
        if (tb_side_reg.func == FUNC_LOAD) begin
            status = ST_OK;
        end else if (tb_side_reg.bad_ino) begin
            status = ST_BAD_INO;
        end else if (tb_bad_grp_reg) begin
            status = ST_BAD_GRP;
        end else begin
            status = ST_OK;
        end
        if (tb_side_reg.func == FUNC_LOCATE && status == ST_OK) begin
            blk = {13'd0, tb_start_reg} + (tb_bytes_reg >> shamt);
            off = tb_bytes_reg[11:0] & 12'((13'd1 << shamt) - 13'd1);
        end else begin
            blk = '0;
            off = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= tb_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= {5'd0, off, blk, status};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule
